// File: design/png_chunk_walker_core_macros.svh
// Assertion macros for the chunk walker port-level checker.
`ifndef PNG_CHUNK_WALKER_CORE_MACROS_SVH
`define PNG_CHUNK_WALKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("png chunk walker check failed");

// Next-cycle implication, disabled during reset.
`define PCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("png chunk walker check failed");

`endif

// File: design/png_cw_pkg.sv
// Types and constants for the PNG chunk walker.
package png_cw_pkg;

  localparam int unsigned OFF_W   = 40;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MAX_CHUNKS_RST = 16'd10000;

  localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [7:0]  ANCILLARY_BIT = 8'h20;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EARLY     = 3'd1;
  localparam logic [2:0] ST_HDR_TRUNC = 3'd2;
  localparam logic [2:0] ST_BAD_SIG   = 3'd3;
  localparam logic [2:0] ST_SHORT_SIG = 3'd4;
  localparam logic [2:0] ST_TOO_MANY  = 3'd5;

  localparam logic [2:0] CLS_HEADER    = 3'd0;
  localparam logic [2:0] CLS_IMAGE     = 3'd1;
  localparam logic [2:0] CLS_END       = 3'd2;
  localparam logic [2:0] CLS_ANCILLARY = 3'd3;
  localparam logic [2:0] CLS_CRITICAL  = 3'd4;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [31:0]      ctype;
    logic [2:0]       cls;
    logic [CNT_W-1:0] count;
    logic             saw_header;
    logic             saw_end;
    logic             file_done;
    logic             last;
  } rec_t;

  function automatic rec_t mk_rec(input logic [2:0] status, input logic [OFF_W-1:0] off,
                                  input logic [LEN_W-1:0] len, input logic [31:0] typ,
                                  input logic [2:0] cls, input logic done);
    rec_t r;
    r            = '0;
    r.status     = status;
    r.offset     = off;
    r.length     = len;
    r.ctype      = typ;
    r.cls        = cls;
    r.file_done  = done;
    return r;
  endfunction

endpackage

// File: design/png_chunk_walker_core.sv
// PNG chunk walker: signature check, chunk framing and record queue.
// Records are written into the queue when their byte is accepted.
// Throughput: one byte per cycle while in_stall is low; records leave one per
// cycle from a 4-deep queue while out_stall is low, and the input stalls while
// fewer than two queue slots are free. Reset (synchronous, rst_n low) sets
// max_chunks to 10000, empties the queue and starts a new file.
module png_chunk_walker_core
  import png_cw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_file,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_record_status,
  output logic [OFF_W-1:0] out_chunk_offset,
  output logic [LEN_W-1:0] out_chunk_length,
  output logic [31:0]      out_chunk_type,
  output logic [2:0]       out_chunk_class,
  output logic [CNT_W-1:0] out_chunk_count,
  output logic             out_saw_header,
  output logic             out_saw_end,
  output logic             out_file_done,
  output logic             out_last_result
);

  phase_t            phase_r, phase_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [31:0]       type_r, type_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [OFF_W-1:0]  cstart_r, cstart_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              hs_r, hs_nxt;
  logic              es_r, es_nxt;
  logic              sigbad_r, sigbad_nxt;
  logic [CNT_W-1:0]  maxc_r;

  rec_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  logic              in_acc, out_acc;
  rec_t              rec0, rec1;
  logic [1:0]        n_rec;
  rec_t              head;

  assign in_stall  = (fill_r > (QPTR_W+1)'(QDEPTH - 2));
  assign out_valid = (fill_r != '0);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    logic [3:0] idx_inc;
    logic       fin_req;
    logic [2:0] fin_status;
    logic       done;
    logic       clear;
    logic       eof;
    logic [2:0] cls;
    logic       is_end;
    logic       abort_now;
    logic       fin_done;

    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    rem_nxt    = rem_r;
    off_nxt    = off_r;
    cstart_nxt = cstart_r;
    count_nxt  = count_r;
    hs_nxt     = hs_r;
    es_nxt     = es_r;
    sigbad_nxt = sigbad_r;
    rec0       = '0;
    rec1       = '0;
    n_rec      = 2'd0;
    idx_inc    = {1'b0, idx_r} + 4'd1;
    fin_req    = 1'b0;
    fin_status = ST_OK;
    done       = 1'b0;
    clear      = 1'b0;
    eof        = in_end_of_file;
    cls        = CLS_CRITICAL;
    is_end     = 1'b0;
    abort_now  = 1'b0;
    fin_done   = 1'b0;

    if (in_acc) begin
      if (phase_r == PH_DONE) begin
        clear = eof;
      end else begin
        if (off_r != OFF_MAX) begin
          off_nxt = off_r + OFF_W'(1);
        end
        case (phase_r)
          PH_SIG: begin
            if (in_data_byte != PNG_MAGIC[idx_r]) begin
              sigbad_nxt = 1'b1;
            end
            idx_nxt = idx_inc[2:0];
            if (idx_inc[3]) begin
              if (sigbad_nxt) begin
                rec0  = mk_rec(ST_BAD_SIG, '0, '0, '0, '0, 1'b1);
                n_rec = 2'd1;
                done  = 1'b1;
              end else begin
                phase_nxt  = PH_LEN;
                idx_nxt    = '0;
                len_nxt    = '0;
                type_nxt   = '0;
                rem_nxt    = '0;
                cstart_nxt = off_nxt;
                if (eof) begin
                  rec0  = mk_rec(ST_HDR_TRUNC, off_nxt, '0, '0, '0, 1'b1);
                  n_rec = 2'd1;
                  done  = 1'b1;
                end
              end
            end else if (eof) begin
              rec0  = mk_rec(ST_SHORT_SIG, '0, '0, '0, '0, 1'b1);
              n_rec = 2'd1;
              done  = 1'b1;
            end
          end
          PH_LEN: begin
            len_nxt = {len_r[LEN_W-9:0], in_data_byte};
            if (idx_inc[2]) begin
              idx_nxt   = '0;
              phase_nxt = PH_TYPE;
            end else begin
              idx_nxt = idx_inc[2:0];
            end
            if (eof) begin
              rec0  = mk_rec(ST_HDR_TRUNC, cstart_r, '0, '0, '0, 1'b1);
              n_rec = 2'd1;
              done  = 1'b1;
            end
          end
          PH_TYPE: begin
            type_nxt = {type_r[23:0], in_data_byte};
            if (idx_inc[2]) begin
              idx_nxt   = '0;
              rem_nxt   = len_r;
              phase_nxt = (len_r != '0) ? PH_DATA : PH_CRC;
              if (eof) begin
                fin_req    = 1'b1;
                fin_status = ST_EARLY;
              end
            end else begin
              idx_nxt = idx_inc[2:0];
              if (eof) begin
                rec0  = mk_rec(ST_HDR_TRUNC, cstart_r, '0, '0, '0, 1'b1);
                n_rec = 2'd1;
                done  = 1'b1;
              end
            end
          end
          PH_DATA: begin
            rem_nxt = rem_r - LEN_W'(1);
            if (rem_nxt == '0) begin
              phase_nxt = PH_CRC;
            end
            if (eof) begin
              fin_req    = 1'b1;
              fin_status = ST_EARLY;
            end
          end
          PH_CRC: begin
            idx_nxt = idx_inc[2:0];
            if (idx_inc[2]) begin
              fin_req    = 1'b1;
              fin_status = ST_OK;
            end else if (eof) begin
              fin_req    = 1'b1;
              fin_status = ST_EARLY;
            end
          end
          default: begin
            phase_nxt = PH_SIG;
          end
        endcase

        if (fin_req) begin
          if (type_nxt == TYPE_IHDR) begin
            cls    = CLS_HEADER;
            hs_nxt = 1'b1;
          end else if (type_nxt == TYPE_IDAT) begin
            cls = CLS_IMAGE;
          end else if (type_nxt == TYPE_IEND) begin
            cls    = CLS_END;
            es_nxt = 1'b1;
            is_end = 1'b1;
          end else if ((type_nxt[31:24] & ANCILLARY_BIT) != '0) begin
            cls = CLS_ANCILLARY;
          end else begin
            cls = CLS_CRITICAL;
          end
          if (count_r != CNT_MAX) begin
            count_nxt = count_r + CNT_W'(1);
          end
          abort_now = !is_end && (count_nxt > maxc_r);
          fin_done  = is_end || (!abort_now && (fin_status == ST_EARLY));
          rec0  = mk_rec(fin_status, cstart_r, len_nxt, type_nxt, cls, fin_done);
          n_rec = 2'd1;
          done  = fin_done;
          if (!fin_done) begin
            phase_nxt  = PH_LEN;
            idx_nxt    = '0;
            len_nxt    = '0;
            type_nxt   = '0;
            rem_nxt    = '0;
            cstart_nxt = off_nxt;
            if (abort_now) begin
              rec1  = mk_rec(ST_TOO_MANY, off_nxt, '0, '0, '0, 1'b1);
              n_rec = 2'd2;
              done  = 1'b1;
            end else if (eof) begin
              rec1  = mk_rec(ST_HDR_TRUNC, off_nxt, '0, '0, '0, 1'b1);
              n_rec = 2'd2;
              done  = 1'b1;
            end
          end
        end

        if (done) begin
          if (eof) begin
            clear = 1'b1;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
    end

    rec0.count      = count_nxt;
    rec0.saw_header = hs_nxt;
    rec0.saw_end    = es_nxt;
    rec0.last       = (n_rec == 2'd1);
    rec1.count      = count_nxt;
    rec1.saw_header = hs_nxt;
    rec1.saw_end    = es_nxt;
    rec1.last       = 1'b1;

    if (clear) begin
      phase_nxt  = PH_SIG;
      idx_nxt    = '0;
      len_nxt    = '0;
      type_nxt   = '0;
      rem_nxt    = '0;
      off_nxt    = '0;
      cstart_nxt = '0;
      count_nxt  = '0;
      hs_nxt     = 1'b0;
      es_nxt     = 1'b0;
      sigbad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      idx_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      rem_r    <= '0;
      off_r    <= '0;
      cstart_r <= '0;
      count_r  <= '0;
      hs_r     <= 1'b0;
      es_r     <= 1'b0;
      sigbad_r <= 1'b0;
      maxc_r   <= MAX_CHUNKS_RST;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      rem_r    <= rem_nxt;
      off_r    <= off_nxt;
      cstart_r <= cstart_nxt;
      count_r  <= count_nxt;
      hs_r     <= hs_nxt;
      es_r     <= es_nxt;
      sigbad_r <= sigbad_nxt;
      if (cfg_wr_en) begin
        maxc_r <= cfg_wr_data;
      end
    end
  end

  // record queue
  always_ff @(posedge clk) begin
    if (n_rec != 2'd0) begin
      q_mem_r[wr_ptr_r] <= rec0;
    end
    if (n_rec == 2'd2) begin
      q_mem_r[wr_ptr_r + QPTR_W'(1)] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_rec);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      fill_r <= fill_r + (QPTR_W+1)'(n_rec) - (QPTR_W+1)'(out_acc);
    end
  end

  assign head              = q_mem_r[rd_ptr_r];
  assign out_record_status = head.status;
  assign out_chunk_offset  = head.offset;
  assign out_chunk_length  = head.length;
  assign out_chunk_type    = head.ctype;
  assign out_chunk_class   = head.cls;
  assign out_chunk_count   = head.count;
  assign out_saw_header    = head.saw_header;
  assign out_saw_end       = head.saw_end;
  assign out_file_done     = head.file_done;
  assign out_last_result   = head.last;

endmodule

// File: design/png_cw_checker.sv
// Port-level checks for the PNG chunk walker, bound to the walker core.
`include "png_chunk_walker_core_macros.svh"

module png_cw_checker
  import png_cw_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [2:0]       out_record_status,
  input logic [OFF_W-1:0] out_chunk_offset,
  input logic [LEN_W-1:0] out_chunk_length,
  input logic [31:0]      out_chunk_type,
  input logic [2:0]       out_chunk_class,
  input logic             out_file_done,
  input logic             out_last_result
);

  `PCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  `PCW_ASSERT_NOW(a_abort_ends, clk, rst_n,
    out_valid && (out_record_status == ST_TOO_MANY), out_file_done && out_last_result)

  `PCW_ASSERT_NOW(a_sig_zero, clk, rst_n,
    out_valid && ((out_record_status == ST_BAD_SIG) || (out_record_status == ST_SHORT_SIG)),
    (out_chunk_offset == '0) && (out_chunk_length == '0) && (out_chunk_type == '0))

  `PCW_ASSERT_NOW(a_trunc_rec, clk, rst_n,
    out_valid && (out_record_status == ST_HDR_TRUNC),
    out_file_done && out_last_result && (out_chunk_length == '0) &&
    (out_chunk_class == CLS_HEADER))

endmodule

bind png_chunk_walker_core png_cw_checker u_png_cw_checker (.*);

// File: verif/png_chunk_walker_checker.sv
// Checker for the PNG chunk walker: predicts chunk records and compares them with the output.
module png_chunk_walker_checker
  import png_cw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_file,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [2:0]       out_record_status,
  input  logic [OFF_W-1:0] out_chunk_offset,
  input  logic [LEN_W-1:0] out_chunk_length,
  input  logic [31:0]      out_chunk_type,
  input  logic [2:0]       out_chunk_class,
  input  logic [CNT_W-1:0] out_chunk_count,
  input  logic             out_saw_header,
  input  logic             out_saw_end,
  input  logic             out_file_done,
  input  logic             out_last_result,
  output int               errors,
  output int               pending,
  output int               records_seen,
  output int               words_parsed
);

  localparam logic [31:0] IHDR_WORD = 32'h4948_4452;
  localparam logic [31:0] IDAT_WORD = 32'h4944_4154;
  localparam logic [31:0] IEND_WORD = 32'h4945_4E44;

  logic [CNT_W-1:0] limit_q;
  phase_t           ph;
  logic [3:0]       idx;
  logic [31:0]      len_sh;
  logic [31:0]      type_sh;
  logic [31:0]      data_rem;
  logic [OFF_W-1:0] boff;
  logic [OFF_W-1:0] cstart;
  logic [CNT_W-1:0] nchunks;
  logic             hdr_seen;
  logic             iend_seen;
  logic             sig_bad;

  rec_t expected_records[$];

  initial begin
    errors       = 0;
    pending      = 0;
    records_seen = 0;
    words_parsed = 0;
  end

  function automatic void clear_file();
    ph        = PH_SIG;
    idx       = '0;
    len_sh    = '0;
    type_sh   = '0;
    data_rem  = '0;
    boff      = '0;
    cstart    = '0;
    nchunks   = '0;
    hdr_seen  = 1'b0;
    iend_seen = 1'b0;
    sig_bad   = 1'b0;
  endfunction

  function automatic void open_chunk();
    ph       = PH_LEN;
    idx      = '0;
    len_sh   = '0;
    type_sh  = '0;
    data_rem = '0;
    cstart   = boff;
  endfunction

  function automatic void add_record(input logic [2:0] st, input logic [OFF_W-1:0] off,
                                     input logic [31:0] len, input logic [31:0] typ,
                                     input logic [2:0] cls, input logic done);
    rec_t r;
    r.status     = st;
    r.offset     = off;
    r.length     = len;
    r.ctype      = typ;
    r.cls        = cls;
    r.count      = nchunks;
    r.saw_header = hdr_seen;
    r.saw_end    = iend_seen;
    r.file_done  = done;
    r.last       = 1'b0;
    expected_records.push_back(r);
  endfunction

  function automatic logic close_chunk(input logic [2:0] st, input logic eof);
    logic [2:0] cls;
    logic       is_end;
    logic       abort_now;
    logic       done;
    is_end = 1'b0;
    if (type_sh == IHDR_WORD) begin
      cls      = CLS_HEADER;
      hdr_seen = 1'b1;
    end else if (type_sh == IDAT_WORD) begin
      cls = CLS_IMAGE;
    end else if (type_sh == IEND_WORD) begin
      cls       = CLS_END;
      iend_seen = 1'b1;
      is_end    = 1'b1;
    end else if ((type_sh[31:24] & ANCILLARY_BIT) != 8'h00) begin
      cls = CLS_ANCILLARY;
    end else begin
      cls = CLS_CRITICAL;
    end
    if (nchunks != CNT_MAX) nchunks = nchunks + 1'b1;
    abort_now = !is_end && (nchunks > limit_q);
    done      = is_end || (!abort_now && st == ST_EARLY);
    add_record(st, cstart, len_sh, type_sh, cls, done);
    if (done) return 1'b1;
    open_chunk();
    if (abort_now) begin
      add_record(ST_TOO_MANY, cstart, '0, '0, '0, 1'b1);
      return 1'b1;
    end
    if (eof) begin
      add_record(ST_HDR_TRUNC, cstart, '0, '0, '0, 1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Returns 1 when the word was parsed, 0 when it was dropped after the file ended.
  function automatic logic walk_word(input logic [7:0] b, input logic eof);
    logic done;
    int   first;
    done  = 1'b0;
    first = expected_records.size();
    if (ph == PH_DONE) begin
      if (eof) clear_file();
      return 1'b0;
    end
    if (boff != OFF_MAX) boff = boff + 1'b1;
    case (ph)
      PH_SIG: begin
        if (b != PNG_MAGIC[idx[2:0]]) sig_bad = 1'b1;
        idx = idx + 1'b1;
        if (idx >= 4'd8) begin
          if (sig_bad) begin
            add_record(ST_BAD_SIG, '0, '0, '0, '0, 1'b1);
            done = 1'b1;
          end else begin
            open_chunk();
            if (eof) begin
              add_record(ST_HDR_TRUNC, cstart, '0, '0, '0, 1'b1);
              done = 1'b1;
            end
          end
        end else if (eof) begin
          add_record(ST_SHORT_SIG, '0, '0, '0, '0, 1'b1);
          done = 1'b1;
        end
      end
      PH_LEN: begin
        len_sh = {len_sh[23:0], b};
        idx    = idx + 1'b1;
        if (idx >= 4'd4) begin
          idx = '0;
          ph  = PH_TYPE;
        end
        if (eof) begin
          add_record(ST_HDR_TRUNC, cstart, '0, '0, '0, 1'b1);
          done = 1'b1;
        end
      end
      PH_TYPE: begin
        type_sh = {type_sh[23:0], b};
        idx     = idx + 1'b1;
        if (idx >= 4'd4) begin
          idx      = '0;
          data_rem = len_sh;
          ph       = (len_sh != 32'd0) ? PH_DATA : PH_CRC;
          if (eof) done = close_chunk(ST_EARLY, 1'b1);
        end else if (eof) begin
          add_record(ST_HDR_TRUNC, cstart, '0, '0, '0, 1'b1);
          done = 1'b1;
        end
      end
      PH_DATA: begin
        data_rem = data_rem - 1'b1;
        if (data_rem == 32'd0) ph = PH_CRC;
        if (eof) done = close_chunk(ST_EARLY, 1'b1);
      end
      default: begin
        idx = idx + 1'b1;
        if (idx >= 4'd4) done = close_chunk(ST_OK, eof);
        else if (eof) done = close_chunk(ST_EARLY, 1'b1);
      end
    endcase
    if (done) begin
      if (eof) clear_file();
      else ph = PH_DONE;
    end
    if (expected_records.size() > first)
      expected_records[expected_records.size() - 1].last = 1'b1;
    return 1'b1;
  endfunction

  function automatic int field_diff(input string what, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rec_t want;
    if (!rst_n) begin
      limit_q = MAX_CHUNKS_RST;
      clear_file();
      expected_records.delete();
    end else begin
      if (cfg_wr_en) limit_q = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (walk_word(in_data_byte, in_end_of_file)) words_parsed++;
      end
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, status %0d offset %0h type %0h", $time,
                   out_record_status, out_chunk_offset, out_chunk_type);
          errors++;
        end else begin
          want = expected_records.pop_front();
          errors += field_diff("record_status", 64'(want.status), 64'(out_record_status));
          errors += field_diff("chunk_offset", 64'(want.offset), 64'(out_chunk_offset));
          errors += field_diff("chunk_length", 64'(want.length), 64'(out_chunk_length));
          errors += field_diff("chunk_type", 64'(want.ctype), 64'(out_chunk_type));
          errors += field_diff("chunk_class", 64'(want.cls), 64'(out_chunk_class));
          errors += field_diff("chunk_count", 64'(want.count), 64'(out_chunk_count));
          errors += field_diff("saw_header", 64'(want.saw_header), 64'(out_saw_header));
          errors += field_diff("saw_end", 64'(want.saw_end), 64'(out_saw_end));
          errors += field_diff("file_done", 64'(want.file_done), 64'(out_file_done));
          errors += field_diff("last_result", 64'(want.last), 64'(out_last_result));
          records_seen++;
        end
      end
    end
    pending = expected_records.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the PNG chunk walker testbench: clock, reset, byte stream, stalls and verdict.
module testbench
  import png_cw_pkg::*;
();

  localparam logic [31:0] IHDR_WORD   = 32'h4948_4452;
  localparam logic [31:0] IDAT_WORD   = 32'h4944_4154;
  localparam logic [31:0] IEND_WORD   = 32'h4945_4E44;
  localparam int          HOLD_CYCLES = 300;
  localparam int          QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } word_t;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             cfg_wr_en      = 1'b0;
  logic [15:0]      cfg_wr_data    = '0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte   = '0;
  logic             in_end_of_file = 1'b0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic [2:0]       out_record_status;
  logic [OFF_W-1:0] out_chunk_offset;
  logic [LEN_W-1:0] out_chunk_length;
  logic [31:0]      out_chunk_type;
  logic [2:0]       out_chunk_class;
  logic [CNT_W-1:0] out_chunk_count;
  logic             out_saw_header;
  logic             out_saw_end;
  logic             out_file_done;
  logic             out_last_result;

  int    errors;
  int    pending;
  int    records_seen;
  int    words_parsed;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    hold_left     = 0;
  int    quiet         = 0;
  int    files_sent    = 0;
  logic  hold_req      = 1'b0;
  word_t file_words[$];

  png_chunk_walker_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_status (out_record_status),
    .out_chunk_offset  (out_chunk_offset),
    .out_chunk_length  (out_chunk_length),
    .out_chunk_type    (out_chunk_type),
    .out_chunk_class   (out_chunk_class),
    .out_chunk_count   (out_chunk_count),
    .out_saw_header    (out_saw_header),
    .out_saw_end       (out_saw_end),
    .out_file_done     (out_file_done),
    .out_last_result   (out_last_result)
  );

  png_chunk_walker_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_status (out_record_status),
    .out_chunk_offset  (out_chunk_offset),
    .out_chunk_length  (out_chunk_length),
    .out_chunk_type    (out_chunk_type),
    .out_chunk_class   (out_chunk_class),
    .out_chunk_count   (out_chunk_count),
    .out_saw_header    (out_saw_header),
    .out_saw_end       (out_saw_end),
    .out_file_done     (out_file_done),
    .out_last_result   (out_last_result),
    .errors            (errors),
    .pending           (pending),
    .records_seen      (records_seen),
    .words_parsed      (words_parsed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic put_word(input logic [7:0] b, input logic eof);
    word_t w;
    w.data = b;
    w.eof  = eof;
    file_words.push_back(w);
  endtask

  task automatic put_signature();
    for (int k = 0; k < 8; k++) put_word(PNG_MAGIC[k], 1'b0);
  endtask

  task automatic put_chunk(input logic [31:0] declared, input logic [31:0] typ, input int body);
    for (int k = 3; k >= 0; k--) put_word(declared[8*k +: 8], 1'b0);
    for (int k = 3; k >= 0; k--) put_word(typ[8*k +: 8], 1'b0);
    repeat (body) put_word(8'($urandom_range(0, 255)), 1'b0);
    repeat (4) put_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic logic [31:0] pick_type(input int i, input int n);
    logic [31:0] w;
    w = $urandom;
    if (i == 0 && $urandom_range(0, 4) != 0) return IHDR_WORD;
    if (i == n - 1 && $urandom_range(0, 4) != 0) return IEND_WORD;
    case ($urandom_range(0, 4))
      0: return IDAT_WORD;
      1: return IHDR_WORD;
      2: begin
        w[29] = 1'b1;
        return w;
      end
      3: begin
        w[29] = 1'b0;
        return w;
      end
      default: return w;
    endcase
  endfunction

  task automatic build_random_file();
    int          kind;
    int          n;
    int          cut;
    int          body;
    int          pos;
    logic [31:0] declared;
    word_t       w;
    kind = $urandom_range(0, 99);
    if (kind >= 93) begin
      n = $urandom_range(1, 20);
      repeat (n) put_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      put_signature();
      if (kind >= 85) begin
        pos    = $urandom_range(0, 7);
        w      = file_words[pos];
        w.data = w.data ^ 8'($urandom_range(1, 255));
        file_words[pos] = w;
      end
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (kind >= 70 && kind < 85 && $urandom_range(0, 4) == 0) begin
          declared = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom);
          body     = $urandom_range(0, 30);
        end else begin
          declared = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
          body     = declared;
        end
        put_chunk(declared, pick_type(i, n), body);
      end
      if (kind < 70 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) put_word(8'($urandom_range(0, 255)), 1'b0);
      if (kind >= 70 && kind < 85) begin
        cut = $urandom_range(0, file_words.size() - 1);
        while (file_words.size() > cut + 1) void'(file_words.pop_back());
      end
    end
    w     = file_words[file_words.size() - 1];
    w.eof = 1'b1;
    file_words[file_words.size() - 1] = w;
  endtask

  task automatic send_word(input word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= w.data;
    in_end_of_file <= w.eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_words[k]) send_word(file_words[k]);
    file_words.delete();
    files_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_max_chunks(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int          w0;
    int          r0;
    logic [15:0] limit;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put_word(8'h89, 1'b0);
    put_word(8'h50, 1'b1);
    send_file();
    put_word(8'h00, 1'b0);
    put_word(8'hFF, 1'b0);
    for (int k = 2; k < 7; k++) put_word(PNG_MAGIC[k], 1'b0);
    put_word(8'hFF, 1'b1);
    send_file();
    put_signature();
    put_word(PNG_MAGIC[7], 1'b1);
    void'(file_words.pop_back());
    file_words[file_words.size() - 1] = '{data: PNG_MAGIC[7], eof: 1'b1};
    send_file();
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: limit = 16'd1;
        1: limit = 16'd65534;
        2: limit = 16'd3;
        3: limit = 16'd10000;
        4: limit = 16'($urandom_range(2, 6));
        default: limit = 16'd2;
      endcase
      set_max_chunks(limit);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 51;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 51;
        end
        default: begin
          send_idle_pct = 15;
          stall_pct     = 15;
        end
      endcase
      if (p == 4) hold_req = 1'b1;
      w0 = words_parsed;
      r0 = records_seen;
      while (words_parsed - w0 < 30 || records_seen - r0 < 3) begin
        build_random_file();
        send_file();
      end
      drain();
    end

    stall_pct = 0;
    drain();
    $display("run covered %0d files, %0d parsed bytes and %0d checked records", files_sent,
             words_parsed, records_seen);
    $display("chunk limits 1, 2, 3, 10000 and 65534 under idle, stall and long hold-off mixes");
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
